@@ design/itp_pkg.sv @@
// Package for the infix-to-postfix converter.
// Holds the stack sizing, character codes, state and command types, and the
// character classification and precedence functions. Depends on nothing.
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TERM   = 8'h00;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;
  localparam logic [7:0] CH_LC_LO  = 8'h61;
  localparam logic [7:0] CH_LC_HI  = 8'h7A;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_ALNUM,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OP,
    CLS_END
  } char_class_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_CHAR,
    OUT_TOP,
    OUT_PEND,
    OUT_PEND_LAST,
    OUT_TERM
  } out_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     push;
    logic     pop;
    logic     pend_load;
    out_sel_t out_sel;
  } itp_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        count_zero;
    logic        top_is_lparen;
    logic        top_prec_ge;
    logic        out_free;
    logic        pend_valid;
  } itp_sts_t;

  // Precedence of a stack entry or an operator; '(' and anything else is 0.
  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    case (c) inside
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic char_class_t classify(input logic kind, input logic [7:0] c);
    char_class_t cls;
    if (kind == KIND_END) begin
      cls = CLS_END;
    end else if ((c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_UC_LO && c <= CH_UC_HI) ||
                 (c >= CH_LC_LO && c <= CH_LC_HI)) begin
      cls = CLS_ALNUM;
    end else begin
      case (c) inside
        CH_LPAREN:                                   cls = CLS_LPAREN;
        CH_RPAREN:                                   cls = CLS_RPAREN;
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: cls = CLS_OP;
        default:                                     cls = CLS_OTHER;
      endcase
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ design/itp_if.sv @@
// Valid/ready channel interfaces for the converter's input and output words.
// Depends on nothing.
`default_nettype none

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, output kind, output char_in, input ready);
  modport sink   (input valid, input kind, input char_in, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;
  logic       overflow_seen;
  logic       underflow_seen;

  modport source (output valid, output char_out, output last, output overflow_seen,
                  output underflow_seen, input ready);
  modport sink   (input valid, input char_out, input last, input overflow_seen,
                  input underflow_seen, output ready);
endinterface

`default_nettype wire

@@ design/itp_ctrl.sv @@
// Controller state machine of the infix-to-postfix converter.
// Depends on itp_pkg; drives the datapath through itp_cmd_t.
`default_nettype none

module itp_ctrl
  import itp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire itp_sts_t sts,
  output itp_cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   loop_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.push      = 1'b0;
    cmd.pop       = 1'b0;
    cmd.pend_load = 1'b0;
    cmd.out_sel   = OUT_NONE;
    // The popping loop of ')' stops at '('; that of an operator at lower precedence.
    loop_go = !sts.count_zero &&
              ((sts.cls == CLS_RPAREN) ? !sts.top_is_lparen : sts.top_prec_ge);

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_WORK;
        end
      end
      ST_WORK: begin
        unique case (sts.cls)
          CLS_END: begin
            if (sts.out_free) begin
              if (!sts.count_zero) begin
                cmd.pop     = 1'b1;
                cmd.out_sel = OUT_TOP;
              end else begin
                cmd.out_sel = OUT_TERM;
                state_next  = ST_IDLE;
              end
            end
          end
          CLS_ALNUM: begin
            if (sts.out_free) begin
              cmd.out_sel = OUT_CHAR;
              state_next  = ST_IDLE;
            end
          end
          CLS_LPAREN: begin
            cmd.push   = 1'b1;
            state_next = ST_IDLE;
          end
          CLS_RPAREN, CLS_OP: begin
            if (loop_go) begin
              if (!sts.pend_valid || sts.out_free) begin
                cmd.pop       = 1'b1;
                cmd.pend_load = 1'b1;
                if (sts.pend_valid) begin
                  cmd.out_sel = OUT_PEND;
                end
              end
            end else if (!sts.pend_valid || sts.out_free) begin
              if (sts.pend_valid) begin
                cmd.out_sel = OUT_PEND_LAST;
              end
              if (sts.cls == CLS_RPAREN) begin
                cmd.pop = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
              state_next = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/itp_datapath.sv @@
// Datapath of the infix-to-postfix converter: item register, operator stack
// memory with registered top read, stack count, sticky flags, held result
// and output register. Depends on itp_pkg.
`default_nettype none

module itp_datapath
  import itp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       kind,
  input  wire logic [7:0] char_in,
  input  wire itp_cmd_t   cmd,
  output itp_sts_t        sts,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [7:0]      char_out,
  output logic            last,
  output logic            overflow_seen,
  output logic            underflow_seen
);

  logic [7:0]         mem [STACK_DEPTH];
  logic               cur_kind;
  logic [7:0]         cur_char;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] count_dec;
  logic [STACK_AW-1:0] rd_addr;
  logic [7:0]         top;
  logic               overflow_flag;
  logic               underflow_flag;
  logic [7:0]         pend;
  logic               pend_valid;
  logic               push_ok;
  logic               pop_ok;

  assign push_ok   = cmd.push && (count < COUNT_W'(STACK_DEPTH));
  assign pop_ok    = cmd.pop && (count != '0);
  assign count_next = push_ok ? count + COUNT_W'(1) :
                      (pop_ok ? count - COUNT_W'(1) : count);
  assign count_dec = count_next - COUNT_W'(1);
  assign rd_addr   = count_dec[STACK_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur_kind <= kind;
      cur_char <= char_in;
    end
  end

  // The read port always follows the entry that will be on top next cycle;
  // a push writes exactly that entry, so its data is forwarded.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[count[STACK_AW-1:0]] <= cur_char;
      top                      <= cur_char;
    end else begin
      top <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      overflow_flag  <= 1'b0;
      underflow_flag <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.out_sel == OUT_TERM) begin
        overflow_flag  <= 1'b0;
        underflow_flag <= 1'b0;
      end else begin
        if (cmd.push && !push_ok) begin
          overflow_flag <= 1'b1;
        end
        if (cmd.pop && !pop_ok) begin
          underflow_flag <= 1'b1;
        end
      end
      if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end else if (cmd.out_sel == OUT_PEND_LAST) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend <= top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_sel != OUT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.out_sel)
      OUT_CHAR: begin
        char_out       <= cur_char;
        last           <= 1'b1;
        overflow_seen  <= 1'b0;
        underflow_seen <= 1'b0;
      end
      OUT_TOP: begin
        char_out       <= top;
        last           <= 1'b0;
        overflow_seen  <= 1'b0;
        underflow_seen <= 1'b0;
      end
      OUT_PEND, OUT_PEND_LAST: begin
        char_out       <= pend;
        last           <= (cmd.out_sel == OUT_PEND_LAST);
        overflow_seen  <= 1'b0;
        underflow_seen <= 1'b0;
      end
      OUT_TERM: begin
        char_out       <= CH_TERM;
        last           <= 1'b1;
        overflow_seen  <= overflow_flag;
        underflow_seen <= underflow_flag;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.cls           = classify(cur_kind, cur_char);
    sts.count_zero    = (count == '0);
    sts.top_is_lparen = (top == CH_LPAREN);
    sts.top_prec_ge   = (prec(top) >= prec(cur_char));
    sts.out_free      = !out_valid || out_ready;
    sts.pend_valid    = pend_valid;
  end

endmodule

`default_nettype wire

@@ design/infix_to_postfix_converter.sv @@
// Infix-to-postfix converter (shunting-yard) top level; uses itp_pkg, itp_if.
// A word is accepted while the controller is idle. The controller then works on
// it, popping operators from the stack one at a time and waiting while the
// output is stalled, and takes no new word until it is through with the last.
// Popped operators are read through the stack memory's registered read port.
// Reset (rst, synchronous, active high) empties the stack and clears both flags.
`default_nettype none

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  itp_in_if.sink    expr,
  itp_out_if.source postfix
);

  // The controller sequences one input word at a time. Letters and digits go
  // straight to the output register; '(' is pushed; ')' and operators pop
  // into a one-entry hold register so that the last popped character can be
  // marked before it leaves; the end word drains the stack and then sends the
  // zero terminator carrying the sticky overflow and underflow flags.
  itp_cmd_t cmd;
  itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (expr.valid),
    .in_ready (expr.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath's output register separates the two sides, so a word may be
  // taken while a finished result still waits for the sink.
  itp_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .kind           (expr.kind),
    .char_in        (expr.char_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (postfix.ready),
    .out_valid      (postfix.valid),
    .char_out       (postfix.char_out),
    .last           (postfix.last),
    .overflow_seen  (postfix.overflow_seen),
    .underflow_seen (postfix.underflow_seen)
  );

endmodule

`default_nettype wire

@@ design/itp_checker.sv @@
// Port-level checks for the infix-to-postfix converter, bound to its top level.
// Depends on itp_pkg for the terminator code and on the top level's channel ports.
`default_nettype none

module itp_checker
  import itp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] char_out,
  input wire logic       last,
  input wire logic       overflow_seen,
  input wire logic       underflow_seen
);

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_word_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(char_out) && $stable(last))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word presented right after reset");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_out == CH_TERM |-> last)
    else $error("terminator not marked last");

  a_flags_on_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && (overflow_seen || underflow_seen) |-> char_out == CH_TERM)
    else $error("stack flags reported on a non-terminator word");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (postfix.valid),
  .out_ready      (postfix.ready),
  .char_out       (postfix.char_out),
  .last           (postfix.last),
  .overflow_seen  (postfix.overflow_seen),
  .underflow_seen (postfix.underflow_seen)
);

`default_nettype wire
